[hdl/pgpu_pkg.sv]
// ----------------------------------------------------------------------------
// Packed glyph pixel unpack package
// Shared widths, reset values, register indexes, sequencer states and the
// pixel width decode used by the unpack core and its channel interfaces.
// ----------------------------------------------------------------------------
package pgpu_pkg;

	localparam int BYTE_W      = 8;
	localparam int VALUE_W     = 8;
	localparam int COORD_W     = 6;
	localparam int BPP_W       = 4;
	localparam int DEPTH_W     = 8;
	localparam int DIM_W       = 7;
	localparam int MAX_DIM_DEF = 64;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam logic [BPP_W-1:0]   BPP_RST   = 4'd2;
	localparam logic [DEPTH_W-1:0] DEPTH_RST = 8'd2;
	localparam logic [DIM_W-1:0]   DIM_RST   = 7'd16;

	localparam logic [3:0] DIV_TOP = 4'd8;

	typedef enum logic [1:0] {
		REG_BPP,
		REG_DEPTH,
		REG_WIDTH,
		REG_HEIGHT
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_PUT
	} state_t;

	// Rounds the pixel width down to 1, 2, 4 or 8 (0 counts as 1) and returns its log2.
	function automatic logic [1:0] bpp_log2(input logic [BPP_W-1:0] bpp);
		logic [1:0] lg;
		if (bpp >= 4'd8) begin
			lg = 2'd3;
		end else if (bpp >= 4'd4) begin
			lg = 2'd2;
		end else if (bpp >= 4'd2) begin
			lg = 2'd1;
		end else begin
			lg = 2'd0;
		end
		return lg;
	endfunction

endpackage

[hdl/pgpu_byte_if.sv]
// ----------------------------------------------------------------------------
// Packed byte channel
// Valid/ready channel that carries one packed source byte and its glyph start
// flag per word.
// ----------------------------------------------------------------------------
interface pgpu_byte_if;
	import pgpu_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] packed_byte;
	logic              glyph_start;

	modport source (output valid, output packed_byte, output glyph_start, input ready);
	modport sink (input valid, input packed_byte, input glyph_start, output ready);
endinterface

interface pgpu_pix_if;
	import pgpu_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] pixel_value;
	logic [COORD_W-1:0] column;
	logic [COORD_W-1:0] flipped_row;
	logic               last_pixel;
	logic               last_of_byte;

	modport source (output valid, output pixel_value, output column, output flipped_row,
		output last_pixel, output last_of_byte, input ready);
	modport sink (input valid, input pixel_value, input column, input flipped_row,
		input last_pixel, input last_of_byte, output ready);
endinterface

[hdl/packed_glyph_pixel_unpack_core.sv]
// ----------------------------------------------------------------------------
// Sequence: a bit mode pixel passes ST_LOAD and ST_PUT on its way to the output
// register; a gray pixel passes ST_LOAD, the ST_DIV steps and ST_PUT, and a
// saturated gray pixel leaves ST_DIV after its first compare. ST_PUT waits on
// output back-pressure; a new byte is taken only in ST_IDLE, after the last pixel of the previous byte is put.
// Reset loads the register defaults and clears the counters; no clearing pass.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// Packed glyph pixel unpack core
// Splits packed glyph bytes into pixels with column and bottom-up row, and
// scales gray levels through a shared iterative divider.
// ----------------------------------------------------------------------------
module packed_glyph_pixel_unpack_core #(
	parameter int MAX_DIM = pgpu_pkg::MAX_DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pgpu_pkg::APB_AW-1:0]   paddr,
	input  logic [pgpu_pkg::APB_DW-1:0]   pwdata,
	output logic [pgpu_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	pgpu_byte_if.sink                     byte_in,
	pgpu_pix_if.source                    pix_out
);
	import pgpu_pkg::*;

	localparam int CW = $clog2(MAX_DIM);
	localparam int DW = ($clog2(MAX_DIM + 1) > DIM_W) ? $clog2(MAX_DIM + 1) : DIM_W;

	logic [BPP_W-1:0]   bpp_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;

	state_t st_q, st_d;

	logic [CW-1:0]      x_q, y_q;
	logic               done_q;
	logic [BYTE_W-1:0]  byte_q;
	logic [1:0]         lg_q;
	logic [2:0]         idx_q;
	logic [15:0]        rem_q;
	logic [3:0]         div_i_q;
	logic [VALUE_W-1:0] val_q;

	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [COORD_W-1:0] out_col_q;
	logic [COORD_W-1:0] out_row_q;
	logic               out_last_q;
	logic               out_lob_q;

	logic               cfg_wr;
	reg_idx_t           cfg_idx;
	logic               in_fire;
	logic               done_eff;
	logic               put_fire;
	logic [DW-1:0]      w_eff, h_eff;
	logic               row_end, put_last, byte_end;
	logic [COORD_W-1:0] flip_row;
	logic [2:0]         idx_last;
	logic [2:0]         shamt;
	logic [3:0]         bw;
	logic [BYTE_W-1:0]  shifted;
	logic [VALUE_W-1:0] level;
	logic [8:0]         dvs;
	logic [16:0]        sub;
	logic               ge;

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

	always_comb begin
		case (cfg_idx)
			REG_BPP:    prdata = APB_DW'(bpp_q);
			REG_DEPTH:  prdata = APB_DW'(depth_q);
			REG_WIDTH:  prdata = APB_DW'(width_q);
			REG_HEIGHT: prdata = APB_DW'(height_q);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q    <= BPP_RST;
			depth_q  <= DEPTH_RST;
			width_q  <= DIM_RST;
			height_q <= DIM_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_BPP:    bpp_q    <= pwdata[BPP_W-1:0];
				REG_DEPTH:  depth_q  <= pwdata[DEPTH_W-1:0];
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default:    ;
			endcase
		end
	end

	// Effective glyph dimensions and row/glyph end detection.
	always_comb begin
		if (width_q == '0) begin
			w_eff = DW'(1);
		end else if (DW'(width_q) > DW'(MAX_DIM)) begin
			w_eff = DW'(MAX_DIM);
		end else begin
			w_eff = DW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = DW'(1);
		end else if (DW'(height_q) > DW'(MAX_DIM)) begin
			h_eff = DW'(MAX_DIM);
		end else begin
			h_eff = DW'(height_q);
		end
		row_end  = (DW'(x_q) + DW'(1)) >= w_eff;
		put_last = row_end && ((DW'(y_q) + DW'(1)) >= h_eff);
		flip_row = (DW'(y_q) < h_eff) ? COORD_W'(h_eff - DW'(1) - DW'(y_q)) : '0;
		idx_last = 3'((4'd8 >> lg_q) - 4'd1);
		byte_end = put_last || (idx_q == idx_last);
	end

	// Pixel field extraction.
	always_comb begin
		bw      = 4'd1 << lg_q;
		shamt   = 3'(idx_q << lg_q);
		shifted = byte_q << shamt;
		level   = VALUE_W'(shifted >> (4'd8 - bw));
	end

	// Shared divider step: compare and subtract against the shifted divisor.
	always_comb begin
		dvs = 9'(depth_q) + 9'd1;
		sub = 17'(dvs) << div_i_q;
		ge  = {1'b0, rem_q} >= sub;
	end

	// Sequencer next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (in_fire && !done_eff) begin
					st_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				st_d = (lg_q == 2'd0) ? ST_PUT : ST_DIV;
			end
			ST_DIV: begin
				if ((div_i_q == DIV_TOP && ge) || div_i_q == 4'd0) begin
					st_d = ST_PUT;
				end
			end
			ST_PUT: begin
				if (put_fire) begin
					st_d = byte_end ? ST_IDLE : ST_LOAD;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		byte_in.ready = (st_q == ST_IDLE);
		put_fire      = (st_q == ST_PUT) && (!out_valid_q || pix_out.ready);
	end

	assign in_fire  = byte_in.valid & byte_in.ready;
	assign done_eff = byte_in.glyph_start ? 1'b0 : done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			x_q         <= '0;
			y_q         <= '0;
			done_q      <= 1'b0;
			idx_q       <= '0;
			lg_q        <= '0;
			div_i_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (in_fire) begin
				if (byte_in.glyph_start) begin
					x_q    <= '0;
					y_q    <= '0;
					done_q <= 1'b0;
				end
				lg_q  <= bpp_log2(bpp_q);
				idx_q <= '0;
			end
			if (st_q == ST_LOAD) begin
				div_i_q <= DIV_TOP;
			end
			if (st_q == ST_DIV && div_i_q != 4'd0) begin
				div_i_q <= div_i_q - 4'd1;
			end
			if (put_fire) begin
				if (put_last) begin
					done_q <= 1'b1;
				end else if (row_end) begin
					x_q <= '0;
					y_q <= y_q + CW'(1);
				end else begin
					x_q <= x_q + CW'(1);
				end
				idx_q <= idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (pix_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_q <= byte_in.packed_byte;
		end
		case (st_q)
			ST_LOAD: begin
				if (lg_q == 2'd0) begin
					val_q <= level;
				end else begin
					val_q <= '0;
				end
				rem_q <= {level, 8'd0} - {8'd0, level};
			end
			ST_DIV: begin
				if (div_i_q == DIV_TOP) begin
					if (ge) begin
						val_q <= '1;
					end
				end else begin
					if (ge) begin
						rem_q <= 16'({1'b0, rem_q} - sub);
					end
					val_q <= {val_q[VALUE_W-2:0], ge};
				end
			end
			default: ;
		endcase
		if (put_fire) begin
			out_value_q <= val_q;
			out_col_q   <= COORD_W'(x_q);
			out_row_q   <= flip_row;
			out_last_q  <= put_last;
			out_lob_q   <= byte_end;
		end
	end

	assign pix_out.valid        = out_valid_q;
	assign pix_out.pixel_value  = out_value_q;
	assign pix_out.column       = out_col_q;
	assign pix_out.flipped_row  = out_row_q;
	assign pix_out.last_pixel   = out_last_q;
	assign pix_out.last_of_byte = out_lob_q;

	a_done_drops_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && done_q && !byte_in.glyph_start |=> st_q == ST_IDLE)
		else $error("byte after the glyph end started a pixel sequence");

	a_last_ends_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q |-> out_lob_q)
		else $error("last pixel of the glyph does not end its byte");

	a_last_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		put_fire && put_last |=> done_q && st_q == ST_IDLE)
		else $error("glyph end did not stop the sequencer");

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// Packed glyph pixel unpack testbench
// Drives packed glyph bytes through the byte channel and register settings
// through the APB port, predicts every pixel word from a shadow copy of the
// registers and counters, and checks each pixel word field by field in order.
// Directed glyphs cover the field and register extremes, the rounded pixel
// widths, trailing bytes and counters left past shrunken dimensions; random
// glyphs follow, first with random stalls on both channels and then without.
// ----------------------------------------------------------------------------
module tb_top;
	import pgpu_pkg::*;

	localparam int DRAIN_CYCLES = 120;
	localparam int QUIET_LIMIT  = 3000;
	localparam int GLYPH_CAP    = 72;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] flipped_row;
		logic               last_pixel;
		logic               last_of_byte;
	} pixel_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	pgpu_byte_if byte_if ();
	pgpu_pix_if  pix_if ();

	packed_glyph_pixel_unpack_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.byte_in (byte_if),
		.pix_out (pix_if)
	);

	logic [BPP_W-1:0]   shadow_bpp   = BPP_RST;
	logic [DEPTH_W-1:0] shadow_depth = DEPTH_RST;
	logic [DIM_W-1:0]   shadow_width = DIM_RST;
	logic [DIM_W-1:0]   shadow_height = DIM_RST;

	int col_pos;
	int row_pos;
	bit glyph_over;

	pixel_t pixels_due[$];

	int items_sent;
	int pixels_seen;
	int settings_made;
	int mismatch_cnt;
	int quiet_cycles;
	bit idle_on;
	int stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pixel_bits(input logic [BPP_W-1:0] bpp);
		if (bpp >= 4'd8) begin
			return 8;
		end else if (bpp >= 4'd4) begin
			return 4;
		end else if (bpp >= 4'd2) begin
			return 2;
		end
		return 1;
	endfunction

	function automatic int clamp_dim(input logic [DIM_W-1:0] raw);
		if (raw == '0) begin
			return 1;
		end else if (int'(raw) > MAX_DIM_DEF) begin
			return MAX_DIM_DEF;
		end
		return int'(raw);
	endfunction

	function automatic logic [BYTE_W-1:0] rand_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] rand_dim();
		case ($urandom_range(0, 9))
			0: return 7'd0;
			1: return 7'd1;
			2: return 7'($urandom_range(64, 127));
			3: return 7'($urandom_range(9, 63));
			default: return 7'($urandom_range(2, 8));
		endcase
	endfunction

	task automatic unpack_byte(input logic [BYTE_W-1:0] src, input logic start);
		int bw;
		int per_byte;
		int wd;
		int ht;
		int lvl;
		int val;
		int rv;
		int k;
		bit row_end;
		bit fin;
		pixel_t p;
		if (start) begin
			col_pos    = 0;
			row_pos    = 0;
			glyph_over = 1'b0;
		end
		if (glyph_over) begin
			return;
		end
		bw       = pixel_bits(shadow_bpp);
		per_byte = 8 / bw;
		wd       = clamp_dim(shadow_width);
		ht       = clamp_dim(shadow_height);
		for (k = 0; k < per_byte; k++) begin
			lvl = (int'(src) >> (8 - bw * (k + 1))) & ((1 << bw) - 1);
			if (bw == 1) begin
				val = lvl;
			end else begin
				val = (lvl * 255) / (int'(shadow_depth) + 1);
				if (val > 255) begin
					val = 255;
				end
			end
			row_end = (col_pos + 1) >= wd;
			fin     = row_end && ((row_pos + 1) >= ht);
			rv      = (row_pos < ht) ? (ht - 1 - row_pos) : 0;
			p.value        = val[VALUE_W-1:0];
			p.column       = col_pos[COORD_W-1:0];
			p.flipped_row  = rv[COORD_W-1:0];
			p.last_pixel   = fin;
			p.last_of_byte = fin || (k == per_byte - 1);
			pixels_due.insert(pixels_due.size(), p);
			if (fin) begin
				glyph_over = 1'b1;
				break;
			end
			if (row_end) begin
				col_pos = 0;
				row_pos = row_pos + 1;
			end else begin
				col_pos = col_pos + 1;
			end
		end
	endtask

	always @(posedge clk) begin
		if (byte_if.valid && byte_if.ready) begin
			unpack_byte(byte_if.packed_byte, byte_if.glyph_start);
		end
	end

	always @(posedge clk) begin : pixel_check
		pixel_t got;
		pixel_t want;
		if (pix_if.valid && pix_if.ready) begin
			got.value        = pix_if.pixel_value;
			got.column       = pix_if.column;
			got.flipped_row  = pix_if.flipped_row;
			got.last_pixel   = pix_if.last_pixel;
			got.last_of_byte = pix_if.last_of_byte;
			pixels_seen++;
			if (pixels_due.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10) begin
					$display("Unexpected pixel word: value %0d col %0d row %0d last %0b end %0b",
						got.value, got.column, got.flipped_row, got.last_pixel,
						got.last_of_byte);
				end
			end else begin
				want = pixels_due[0];
				pixels_due.delete(0);
				if (got !== want) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10) begin
						$display("Pixel mismatch: want value %0d col %0d row %0d last %0b end %0b",
							want.value, want.column, want.flipped_row, want.last_pixel,
							want.last_of_byte);
						$display("                 got value %0d col %0d row %0d last %0b end %0b",
							got.value, got.column, got.flipped_row, got.last_pixel,
							got.last_of_byte);
					end
				end
			end
		end
	end

	initial begin
		pix_if.ready <= 1'b1;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				stall_left--;
				pix_if.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 10) - 1;
				pix_if.ready <= 1'b0;
			end else begin
				pix_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((byte_if.valid && byte_if.ready) || (pix_if.valid && pix_if.ready) ||
			(psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic send_byte(input logic [BYTE_W-1:0] src, input logic start);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			byte_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_if.valid       <= 1'b1;
		byte_if.packed_byte <= src;
		byte_if.glyph_start <= start;
		@(posedge clk);
		while (!byte_if.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic wait_pixels_out();
		byte_if.valid <= 1'b0;
		@(posedge clk);
		while (pixels_due.size() != 0) @(posedge clk);
	endtask

	task automatic settle();
		wait_pixels_out();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_BPP:    shadow_bpp    = val[BPP_W-1:0];
			REG_DEPTH:  shadow_depth  = val[DEPTH_W-1:0];
			REG_WIDTH:  shadow_width  = val[DIM_W-1:0];
			REG_HEIGHT: shadow_height = val[DIM_W-1:0];
			default: ;
		endcase
		settings_made++;
	endtask

	task automatic set_glyph(input int bpp, input int depth, input int wd, input int ht);
		settle();
		write_reg(REG_BPP, bpp);
		write_reg(REG_DEPTH, depth);
		write_reg(REG_WIDTH, wd);
		write_reg(REG_HEIGHT, ht);
	endtask

	// The glyph begun at reset runs with the default registers and no start flag.
	task automatic test_reset_defaults();
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
	endtask

	// Bit mode with a glyph that ends inside a byte, then a byte past the end.
	task automatic test_bit_mode();
		set_glyph(1, 2, 3, 2);
		send_byte(8'hA5, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b1);
	endtask

	task automatic test_full_width_saturation();
		set_glyph(8, 0, 64, 1);
		send_byte(8'h00, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
	endtask

	task automatic test_single_pixel_glyph();
		set_glyph(4, 255, 0, 0);
		send_byte(8'hF0, 1'b1);
		send_byte(8'h0F, 1'b1);
	endtask

	task automatic test_rounded_widths();
		set_glyph(0, 15, 127, 127);
		send_byte(8'h5A, 1'b1);
		set_glyph(3, 15, 127, 127);
		send_byte(8'hE4, 1'b1);
		set_glyph(7, 15, 127, 127);
		send_byte(8'h1B, 1'b1);
		set_glyph(15, 15, 127, 127);
		send_byte(8'hC3, 1'b1);
	endtask

	// Shrinking the dimensions mid-glyph leaves the counters past the new limits.
	task automatic test_shrink_mid_glyph();
		set_glyph(2, 2, 16, 16);
		send_byte(8'h1B, 1'b1);
		send_byte(8'hE4, 1'b0);
		send_byte(8'h6C, 1'b0);
		settle();
		write_reg(REG_WIDTH, 5);
		send_byte(8'h1B, 1'b0);
		settle();
		write_reg(REG_HEIGHT, 1);
		send_byte(8'hB4, 1'b0);
		send_byte(8'hFF, 1'b0);
	endtask

	task automatic test_random_glyphs(input int item_goal, input bit with_idling);
		int stop_at;
		int phase_end;
		int need;
		int per_byte;
		int k;
		int kind;
		logic [DIM_W-1:0] wd;
		logic [DIM_W-1:0] ht;
		idle_on = with_idling;
		stop_at = items_sent + item_goal;
		while (items_sent < stop_at) begin
			wd = rand_dim();
			ht = rand_dim();
			if (wd > 7'd8 && ht > 7'd8) begin
				ht = 7'($urandom_range(0, 2));
			end
			case ($urandom_range(0, 3))
				0: k = 0;
				1: k = 255;
				default: k = $urandom_range(0, 255);
			endcase
			set_glyph($urandom_range(0, 15), k, int'(wd), int'(ht));
			per_byte  = 8 / pixel_bits(shadow_bpp);
			need      = (clamp_dim(wd) * clamp_dim(ht) + per_byte - 1) / per_byte;
			if (need > GLYPH_CAP) begin
				need = GLYPH_CAP;
			end
			phase_end = items_sent + 40;
			while (items_sent < phase_end && items_sent < stop_at) begin
				kind = $urandom_range(0, 9);
				if (kind <= 6) begin
					send_byte(rand_byte(), 1'b1);
					for (k = 1; k < need; k++) begin
						send_byte(rand_byte(), 1'b0);
					end
					repeat ($urandom_range(0, 2)) send_byte(rand_byte(), 1'b0);
				end else if (kind == 7) begin
					send_byte(rand_byte(), 1'b1);
					repeat ($urandom_range(0, need)) send_byte(rand_byte(), 1'b0);
				end else begin
					repeat ($urandom_range(1, 6)) begin
						send_byte(rand_byte(), (kind == 8) && ($urandom_range(0, 3) == 0));
					end
				end
			end
		end
	endtask

	task automatic test_hold_until_drained();
		int k;
		set_glyph(1, 0, 8, 8);
		send_byte(rand_byte(), 1'b1);
		for (k = 1; k < 4; k++) begin
			send_byte(rand_byte(), 1'b0);
		end
		wait_pixels_out();
		for (k = 4; k < 8; k++) begin
			send_byte(rand_byte(), 1'b0);
		end
	endtask

	initial begin
		arst_n              <= 1'b0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		byte_if.valid       <= 1'b0;
		byte_if.packed_byte <= '0;
		byte_if.glyph_start <= 1'b0;
		col_pos       = 0;
		row_pos       = 0;
		glyph_over    = 1'b0;
		items_sent    = 0;
		pixels_seen   = 0;
		settings_made = 0;
		mismatch_cnt  = 0;
		idle_on       = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_bit_mode();
		test_full_width_saturation();
		test_single_pixel_glyph();
		test_rounded_widths();
		test_shrink_mid_glyph();
		test_random_glyphs(300, 1'b1);
		test_hold_until_drained();
		test_random_glyphs(80, 1'b0);
		settle();

		$display("Sent %0d bytes under %0d register writes and checked %0d pixel words.",
			items_sent, settings_made, pixels_seen);
		$display("Mismatches: %0d, pixel words still owed: %0d.", mismatch_cnt,
			pixels_due.size());
		if (mismatch_cnt == 0 && pixels_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
